FILE: sv/swfmas_pkg.sv
package swfmas_pkg;

  // Default sizes handed to the top level parameters.
  localparam int WINDOW_MAX_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 32;

  // Fixed field widths.
  localparam int CFG_W      = 11;
  localparam int OUT_W      = 42;
  localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

  // Configuration register indexes.
  localparam logic [0:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [0:0] REG_FLIP_COUNT = 1'b1;

  // Datapath commands issued by the controller.
  typedef logic [4:0] op_t;
  localparam op_t OP_NOP       = 5'd0;
  localparam op_t OP_LOAD      = 5'd1;
  localparam op_t OP_EV_RD     = 5'd2;
  localparam op_t OP_EV_SETUP  = 5'd3;
  localparam op_t OP_RM_RD     = 5'd4;
  localparam op_t OP_RM_NEXT   = 5'd5;
  localparam op_t OP_SH_RD     = 5'd6;
  localparam op_t OP_SH_WR     = 5'd7;
  localparam op_t OP_RM_DONE   = 5'd8;
  localparam op_t OP_IN_SETUP  = 5'd9;
  localparam op_t OP_IN_RD     = 5'd10;
  localparam op_t OP_IN_SHIFT  = 5'd11;
  localparam op_t OP_IN_PUT    = 5'd12;
  localparam op_t OP_SM_SETUP  = 5'd13;
  localparam op_t OP_SM_RD     = 5'd14;
  localparam op_t OP_SM_ACC    = 5'd15;
  localparam op_t OP_SM_SWITCH = 5'd16;
  localparam op_t OP_FIN       = 5'd17;

  // Status returned by the datapath.
  typedef struct packed {
    logic evict_need;
    logic found;
    logic sh_more;
    logic in_more;
    logic in_stop;
    logic sm_more;
    logic sel;
    logic out_free;
  } dp_status_t;

endpackage

FILE: sv/swfmas_ctrl.sv
module swfmas_ctrl import swfmas_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t st,
  output op_t        op
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EV_CHK  = 4'd1;
  localparam logic [3:0] S_EV_WAIT = 4'd2;
  localparam logic [3:0] S_RM_RD   = 4'd3;
  localparam logic [3:0] S_RM_CMP  = 4'd4;
  localparam logic [3:0] S_SH_RD   = 4'd5;
  localparam logic [3:0] S_SH_WR   = 4'd6;
  localparam logic [3:0] S_IN      = 4'd7;
  localparam logic [3:0] S_IN_CMP  = 4'd8;
  localparam logic [3:0] S_SM_INIT = 4'd9;
  localparam logic [3:0] S_SM_RD   = 4'd10;
  localparam logic [3:0] S_SM_ACC  = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command for the datapath.
  always_comb begin
    state_nxt = state_r;
    op        = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op        = OP_LOAD;
          state_nxt = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        if (st.evict_need) begin
          op        = OP_EV_RD;
          state_nxt = S_EV_WAIT;
        end else begin
          op        = OP_IN_SETUP;
          state_nxt = S_IN;
        end
      end
      S_EV_WAIT: begin
        op        = OP_EV_SETUP;
        state_nxt = S_RM_RD;
      end
      S_RM_RD: begin
        op        = OP_RM_RD;
        state_nxt = S_RM_CMP;
      end
      S_RM_CMP: begin
        if (st.found) begin
          state_nxt = S_SH_RD;
        end else begin
          op        = OP_RM_NEXT;
          state_nxt = S_RM_RD;
        end
      end
      S_SH_RD: begin
        if (st.sh_more) begin
          op        = OP_SH_RD;
          state_nxt = S_SH_WR;
        end else begin
          op        = OP_RM_DONE;
          state_nxt = S_EV_CHK;
        end
      end
      S_SH_WR: begin
        op        = OP_SH_WR;
        state_nxt = S_SH_RD;
      end
      S_IN: begin
        if (st.in_more) begin
          op        = OP_IN_RD;
          state_nxt = S_IN_CMP;
        end else begin
          op        = OP_IN_PUT;
          state_nxt = S_SM_INIT;
        end
      end
      S_IN_CMP: begin
        if (st.in_stop) begin
          op        = OP_IN_PUT;
          state_nxt = S_SM_INIT;
        end else begin
          op        = OP_IN_SHIFT;
          state_nxt = S_IN;
        end
      end
      S_SM_INIT: begin
        op        = OP_SM_SETUP;
        state_nxt = S_SM_RD;
      end
      S_SM_RD: begin
        if (st.sm_more) begin
          op        = OP_SM_RD;
          state_nxt = S_SM_ACC;
        end else if (!st.sel) begin
          op = OP_SM_SWITCH;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SM_ACC: begin
        op        = OP_SM_ACC;
        state_nxt = S_SM_RD;
      end
      S_FIN: begin
        if (st.out_free) begin
          op        = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/swfmas_dp.sv
module swfmas_dp import swfmas_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  op_t                   op,
  output dp_status_t            st,
  input  logic [DATA_W-1:0]     in_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int SC_W   = SUM_W + 2;

  // Configuration registers.
  logic [CFG_W-1:0] cfg_len_r, cfg_flip_r;

  // Control and payload registers.
  logic [SAMPLE_BITS-1:0] sample_r, mag_r, mag_nxt;
  logic [CNT_W-1:0]       len_eff_r, len_eff_nxt;
  logic [CNT_W-1:0]       fill_r, pos_n_r, neg_n_r, idx_r, n_sel;
  logic [ADDR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic                   sel_r;
  logic [SUM_W-1:0]       pos_tot_r, neg_tot_r, acc_r, ptop_r;
  logic [SC_W-1:0]        best_r, best_nxt;
  logic                   out_valid_r, out_full_r;
  logic [OUT_W-1:0]       out_score_r, out_best_r;

  // Memories.
  logic [SAMPLE_BITS-1:0] delay_mem [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] pos_mem   [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] neg_mem   [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] dl_q, pos_q, neg_q, st_rdata, st_wdata;
  logic [CNT_W-1:0]       ra_full;
  logic [ADDR_W-1:0]      st_raddr;
  logic                   st_we, dl_we;

  // Score path.
  logic signed [SC_W-1:0] s1, s2, smax;
  logic [SC_W-1:0]        score_u;
  logic                   full;
  logic [OUT_W+SC_W-1:0]  score_ext, best_ext;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    r = (p == ADDR_W'(WINDOW_MAX - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] mag_of(input logic [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS-1:0] r;
    r = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  // Window length clamped to 1..WINDOW_MAX.
  always_comb begin
    if (CMP_W'(cfg_len_r) == '0) begin
      len_eff_nxt = CNT_W'(1);
    end else if (CMP_W'(cfg_len_r) > CMP_W'(WINDOW_MAX)) begin
      len_eff_nxt = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff_nxt = CNT_W'(cfg_len_r);
    end
  end

  // Store selection and read address.
  assign n_sel    = sel_r ? neg_n_r : pos_n_r;
  assign st_rdata = sel_r ? neg_q : pos_q;
  assign mag_nxt  = (op == OP_EV_SETUP) ? mag_of(dl_q) : mag_of(sample_r);

  always_comb begin
    unique case (op)
      OP_SH_RD: ra_full = idx_r + 1'b1;
      OP_IN_RD: ra_full = idx_r - 1'b1;
      default:  ra_full = idx_r;
    endcase
  end
  assign st_raddr = ra_full[ADDR_W-1:0];
  assign st_we    = (op == OP_SH_WR) || (op == OP_IN_SHIFT) || (op == OP_IN_PUT);
  assign st_wdata = (op == OP_IN_PUT) ? mag_r : st_rdata;
  assign dl_we    = (op == OP_IN_SETUP);

  // Memory ports with registered read data.
  always_ff @(posedge clk) begin
    if (st_we && !sel_r) begin
      pos_mem[idx_r[ADDR_W-1:0]] <= st_wdata;
    end
    if (st_we && sel_r) begin
      neg_mem[idx_r[ADDR_W-1:0]] <= st_wdata;
    end
    if (dl_we) begin
      delay_mem[wr_ptr_r] <= sample_r;
    end
    pos_q <= pos_mem[st_raddr];
    neg_q <= neg_mem[st_raddr];
    dl_q  <= delay_mem[rd_ptr_r];
  end

  // Status to the controller.
  always_comb begin
    st.evict_need = (fill_r >= len_eff_r);
    st.found      = (st_rdata == mag_r);
    st.sh_more    = ((CNT_W + 1)'(idx_r) + 1'b1) < (CNT_W + 1)'(n_sel);
    st.in_more    = (idx_r != '0);
    st.in_stop    = !(st_rdata < mag_r);
    st.sm_more    = (idx_r < n_sel) && (CMP_W'(idx_r) < CMP_W'(cfg_flip_r));
    st.sel        = sel_r;
    st.out_free   = !out_valid_r || out_tready;
  end

  // Score of the window and running best.
  always_comb begin
    s1 = $signed({2'b00, pos_tot_r}) - $signed({2'b00, neg_tot_r})
       + $signed({1'b0, acc_r, 1'b0});
    s2 = $signed({2'b00, neg_tot_r}) - $signed({2'b00, pos_tot_r})
       + $signed({1'b0, ptop_r, 1'b0});
    smax      = (s1 > s2) ? s1 : s2;
    score_u   = smax[SC_W-1] ? '0 : smax;
    full      = (fill_r == len_eff_r);
    best_nxt  = (full && (score_u > best_r)) ? score_u : best_r;
    score_ext = {{OUT_W{1'b0}}, score_u};
    best_ext  = {{OUT_W{1'b0}}, best_nxt};
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      sample_r  <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (op == OP_FIN) begin
      out_score_r <= score_ext[OUT_W-1:0];
      out_best_r  <= best_ext[OUT_W-1:0];
      out_full_r  <= full;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= CFG_W'(1);
      cfg_flip_r  <= '0;
      len_eff_r   <= CNT_W'(1);
      fill_r      <= '0;
      pos_n_r     <= '0;
      neg_n_r     <= '0;
      idx_r       <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      sel_r       <= 1'b0;
      mag_r       <= '0;
      pos_tot_r   <= '0;
      neg_tot_r   <= '0;
      acc_r       <= '0;
      ptop_r      <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == REG_WINDOW_LEN)) begin
        cfg_len_r <= cfg_data;
      end
      if (cfg_valid && (cfg_index == REG_FLIP_COUNT)) begin
        cfg_flip_r <= cfg_data;
      end
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (op)
        OP_LOAD: len_eff_r <= len_eff_nxt;
        OP_EV_SETUP: begin
          sel_r <= dl_q[SAMPLE_BITS-1];
          mag_r <= mag_nxt;
          idx_r <= '0;
        end
        OP_RM_NEXT: idx_r <= idx_r + 1'b1;
        OP_SH_WR:   idx_r <= idx_r + 1'b1;
        OP_RM_DONE: begin
          if (sel_r) begin
            neg_n_r   <= neg_n_r - 1'b1;
            neg_tot_r <= neg_tot_r - SUM_W'(mag_r);
          end else begin
            pos_n_r   <= pos_n_r - 1'b1;
            pos_tot_r <= pos_tot_r - SUM_W'(mag_r);
          end
          fill_r   <= fill_r - 1'b1;
          rd_ptr_r <= ptr_inc(rd_ptr_r);
        end
        OP_IN_SETUP: begin
          sel_r    <= sample_r[SAMPLE_BITS-1];
          mag_r    <= mag_nxt;
          idx_r    <= sample_r[SAMPLE_BITS-1] ? neg_n_r : pos_n_r;
          wr_ptr_r <= ptr_inc(wr_ptr_r);
          fill_r   <= fill_r + 1'b1;
        end
        OP_IN_SHIFT: idx_r <= idx_r - 1'b1;
        OP_IN_PUT: begin
          if (sel_r) begin
            neg_n_r   <= neg_n_r + 1'b1;
            neg_tot_r <= neg_tot_r + SUM_W'(mag_r);
          end else begin
            pos_n_r   <= pos_n_r + 1'b1;
            pos_tot_r <= pos_tot_r + SUM_W'(mag_r);
          end
        end
        OP_SM_SETUP: begin
          sel_r <= 1'b0;
          idx_r <= '0;
          acc_r <= '0;
        end
        OP_SM_ACC: begin
          acc_r <= acc_r + SUM_W'(st_rdata);
          idx_r <= idx_r + 1'b1;
        end
        OP_SM_SWITCH: begin
          ptop_r <= acc_r;
          sel_r  <= 1'b1;
          idx_r  <= '0;
          acc_r  <= '0;
        end
        OP_FIN: begin
          best_r      <= best_nxt;
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_best_r, out_score_r});
  assign out_tuser  = out_full_r;

`ifndef SYNTHESIS
  // Every sample in the window sits in exactly one store when a result is formed.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_FIN) |-> ((CNT_W + 1)'(pos_n_r) + (CNT_W + 1)'(neg_n_r) == (CNT_W + 1)'(fill_r)))
    else $error("store sizes do not add up to the fill count");

  // The window never holds more samples than its effective length.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_FIN) |-> (fill_r <= len_eff_r))
    else $error("window overfilled");

  // The value being evicted must be found before the end of its store.
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_RM_NEXT) |-> (((CNT_W + 1)'(idx_r) + 1'b1) < (CNT_W + 1)'(n_sel)))
    else $error("evicted value missing from its store");

  // A finished result is never overwritten before it is taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_FIN) |-> (!out_valid_r || out_tready))
    else $error("result overwritten");
`endif

endmodule

FILE: sv/sliding_window_flip_max_abs_sum_top.sv
// Flow: a sample is accepted only in idle; while the window holds its effective length, the
// oldest sample is evicted: it is searched from the top of its sorted store, then the entries
// after it move down one place. The new magnitude is inserted by moving smaller entries up,
// then up to flip_count top entries of each store are summed and the result waits for out_tready.
// Throughput: one transaction in flight; the single read port of each sorted store
// sets the rate, each entry scanned or moved needing a read and then a compare or write.
module sliding_window_flip_max_abs_sum_top import swfmas_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // window_score, best_score
  output logic                  out_tuser,  // window_full
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  // Reset: synchronous active-low rst_n empties the window and stores, clears all sums.
  dp_status_t st;
  op_t        op;

  swfmas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .op        (op)
  );

  swfmas_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .DATA_W      (DATA_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .st         (st),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: bench/tb_sliding_window_flip_max_abs_sum_top.sv
module tb_sliding_window_flip_max_abs_sum_top;
  import swfmas_pkg::*;

  localparam int WMAX = WINDOW_MAX_DEF;
  localparam int SBITS = SAMPLE_BITS_DEF;
  localparam int DW = ((SBITS + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 5000000;

  typedef struct packed {
    logic [OUT_W-1:0] score;
    logic [OUT_W-1:0] best;
    logic             full;
  } score_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [DW-1:0]         in_tdata;    // sample
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // window_score, best_score
  logic                  out_tuser;   // window_full
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [0:0]            cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  sliding_window_flip_max_abs_sum_top i_dut (.*);

  // Predictor state.
  logic [SBITS-1:0] hist[WMAX];
  int               hist_fill;
  int               hist_wr;
  logic [SBITS-1:0] pos_mags[$];
  logic [SBITS-1:0] neg_mags[$];
  logic [OUT_W-1:0] best_seen;
  int               win_len_reg;
  int               flip_reg;

  logic [SBITS-1:0] sample_q[$];
  score_t           expected_q[$];
  int               mismatches;
  int               watchdog;
  bit               hold_sender;
  bit               long_hold_req;
  int               burst_left;
  int               gap_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Insert a magnitude into a descending list.
  function automatic void mag_insert(ref logic [SBITS-1:0] lst[$], input logic [SBITS-1:0] m);
    int i;
    i = 0;
    while (i < lst.size() && lst[i] >= m) i++;
    lst.insert(i, m);
  endfunction

  function automatic void mag_delete(ref logic [SBITS-1:0] lst[$], input logic [SBITS-1:0] m);
    foreach (lst[i]) begin
      if (lst[i] == m) begin
        lst.delete(i);
        return;
      end
    end
  endfunction

  function automatic void route_sample(input logic [SBITS-1:0] raw, input bit add);
    logic [SBITS-1:0] mag;
    mag = raw[SBITS-1] ? (~raw + 1'b1) : raw;
    if (raw[SBITS-1]) begin
      if (add) mag_insert(neg_mags, mag);
      else mag_delete(neg_mags, mag);
    end else begin
      if (add) mag_insert(pos_mags, mag);
      else mag_delete(pos_mags, mag);
    end
  endfunction

  // Window score for one new sample, following the sorted-store split.
  function automatic score_t predict_score(input logic [SBITS-1:0] raw);
    int               len;
    int               idx;
    longint           pt, pr, nt, nr, s1, s2, sc;
    score_t           r;
    len = win_len_reg == 0 ? 1 : (win_len_reg > WMAX ? WMAX : win_len_reg);
    while (hist_fill >= len) begin
      idx = (hist_wr + WMAX - hist_fill) % WMAX;
      route_sample(hist[idx], 1'b0);
      hist_fill--;
    end
    hist[hist_wr] = raw;
    hist_wr = (hist_wr + 1) % WMAX;
    hist_fill++;
    route_sample(raw, 1'b1);
    pt = 0; pr = 0; nt = 0; nr = 0;
    foreach (pos_mags[i]) if (i < flip_reg) pt += pos_mags[i]; else pr += pos_mags[i];
    foreach (neg_mags[i]) if (i < flip_reg) nt += neg_mags[i]; else nr += neg_mags[i];
    s1 = pt + pr + nt - nr;
    s2 = nt + nr + pt - pr;
    sc = s1 > s2 ? s1 : s2;
    if (sc < 0) sc = 0;
    r.full = (hist_fill == len);
    if (r.full && sc > longint'(best_seen)) best_seen = sc[OUT_W-1:0];
    r.score = sc[OUT_W-1:0];
    r.best = best_seen;
    return r;
  endfunction

  // Sender: bursts with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      logic hs;
      logic [SBITS-1:0] s;
      hs = in_tvalid && in_tready;
      if (hs) expected_q.push_back(predict_score(in_tdata[SBITS-1:0]));
      if (!in_tvalid || hs) begin
        if (hold_sender || sample_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else begin
          s = sample_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= DW'(s);
          if (burst_left <= 0) begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: random stall pattern, with an optional long hold-off.
  int stall_mode;
  int long_count;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_mode <= 0;
      long_count <= 0;
    end else if (long_hold_req && long_count == 0 && stall_mode != 9) begin
      stall_mode <= 9;
      long_count <= 3000;
      out_tready <= 1'b0;
    end else if (long_count > 0) begin
      long_count <= long_count - 1;
      out_tready <= (long_count == 1);
    end else begin
      stall_mode <= ($urandom_range(0, 63) == 0) ? $urandom_range(0, 2) : stall_mode;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Checker of every result transaction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      score_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %h", out_tdata);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_tdata[OUT_W-1:0] !== exp_r.score || out_tdata[2*OUT_W-1:OUT_W] !== exp_r.best
            || out_tuser !== exp_r.full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected score %0d best %0d full %0b, got %0d %0d %0b",
                     exp_r.score, exp_r.best, exp_r.full, out_tdata[OUT_W-1:0],
                     out_tdata[2*OUT_W-1:OUT_W], out_tuser);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [0:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_WINDOW_LEN) win_len_reg = value;
    else flip_reg = value;
  endtask

  task automatic drain();
    wait (sample_q.size() == 0 && !in_tvalid && expected_q.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [SBITS-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return SBITS'($urandom_range(0, 20)) - 10;
      1: return SBITS'($urandom) | {1'b1, {(SBITS - 1){1'b0}}};
      2: return SBITS'($urandom) >> 1;
      3: return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return SBITS'($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  initial begin
    int lens[6] = '{1, 3, 8, 0, 1024, 1500};
    int flips[6] = '{0, 1, 3, 1024, 2047, 2};
    int per;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_WINDOW_LEN;
    cfg_data = '0;
    hold_sender = 1'b0;
    long_hold_req = 1'b0;
    mismatches = 0;
    hist_fill = 0;
    hist_wr = 0;
    best_seen = '0;
    win_len_reg = 1;
    flip_reg = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes and sign cases with reset settings, then a small window.
    sample_q = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h1};
    drain();
    write_reg(REG_WINDOW_LEN, 4);
    write_reg(REG_FLIP_COUNT, 1);
    sample_q = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h5, 32'hffff_fffb,
                 32'h5, 32'h0, 32'hffff_fff0, 32'h3, 32'h3};
    drain();
    // Lowering the window evicts the oldest samples at the next step.
    write_reg(REG_WINDOW_LEN, 2);
    sample_q = '{32'h9, 32'hffff_fff7, 32'h2};
    drain();

    // Random phases across window and flip settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_WINDOW_LEN, lens[ph]);
      write_reg(REG_FLIP_COUNT, flips[ph]);
      per = (lens[ph] >= 1024) ? 40 : 70;
      for (int k = 0; k < per; k++) sample_q.push_back(rand_sample());
      if (ph == 2) begin
        // Block fills and stalls its input while the receiver holds off.
        long_hold_req = 1'b1;
        wait (stall_mode == 9);
        long_hold_req = 1'b0;
      end
      if (ph == 4) begin
        wait (sample_q.size() < 20);
        hold_sender = 1'b1;
        wait (expected_q.size() == 0 && !in_tvalid);
        hold_sender = 1'b0;
      end
      drain();
    end
    // Lower the window after a large one.
    write_reg(REG_WINDOW_LEN, 6);
    for (int k = 0; k < 40; k++) sample_q.push_back(rand_sample());
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
